// ----- rtl/sfr_pkg.sv -----
// Shared constants, types and a helper function of the stream find-and-replace block.
package sfr_pkg;

  localparam int BYTE_W       = 8;
  localparam int TEXT_BYTES   = 16;
  localparam int TEXT_W       = TEXT_BYTES * BYTE_W;
  localparam int BIDX_W       = 4;
  localparam int LEN_W        = 5;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int RESULT_CAP   = 16;
  localparam int USER_W       = 2;

  localparam int DEF_MAX_PATTERN     = 16;
  localparam int DEF_MAX_REPLACEMENT = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REP_LO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REP_HI  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REP_LEN = 3'd5;

  // One byte pushed from the sequencer toward the output stage.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } push_t;

  // End-of-transaction request: closes the run of results of one input byte.
  typedef struct packed {
    logic valid;
    logic last;
  } fin_t;

  function automatic logic [BYTE_W-1:0] pick_byte(input logic [TEXT_W-1:0] v,
                                                  input logic [BIDX_W-1:0] i);
    return v[i*BYTE_W +: BYTE_W];
  endfunction

endpackage

// ----- rtl/stream_find_replace_top.sv -----
// Top level of the stream find-and-replace block.
//
// The input stream carries one text byte per transaction, with tlast on the
// final byte of the stream. Every non-overlapping occurrence of the configured
// pattern is replaced by the configured replacement; bytes that may start a
// match are held until a mismatch, a completed match or the stream end.
// Each input byte yields zero to sixteen output transactions; tlast marks the
// last one caused by that byte, tuser[1] the last of the whole stream, and
// tuser[0] low marks an empty end marker.
// An input byte passes through the steps accept, compare and close. A text
// byte sent at the compare needs no extra step; released, replacement and
// flushed bytes each take a step of their own, a fallback step of a partial
// match goes through the release state and back to the compare, and a
// completed match or a flush ends with a step of its own. These steps follow
// from the single byte comparator and the output path, which takes one byte
// per cycle unless the receiver stalls. A pattern register write rebuilds
// the fallback table with in_tready low; reset starts it for the empty pattern.
// When the receiver stalls, one result waits in the output register and one
// more in the hold register; the sequencer then stops until space frees up.
module stream_find_replace_top #(
  parameter int MAX_PATTERN     = sfr_pkg::DEF_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = sfr_pkg::DEF_MAX_REPLACEMENT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sfr_pkg::BYTE_W-1:0]      in_tdata,   // [7:0] in_byte
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sfr_pkg::BYTE_W-1:0]      out_tdata,  // [7:0] out_byte
  output logic [sfr_pkg::USER_W-1:0]      out_tuser,  // [0] byte_valid, [1] stream_end
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import sfr_pkg::*;

  logic [TEXT_W-1:0] pattern;
  logic [TEXT_W-1:0] replacement;
  logic [LEN_W-1:0]  pat_len;
  logic [LEN_W-1:0]  rep_len;
  logic              pat_wr;
  push_t             push;
  logic              push_ready;
  fin_t              fin;
  logic              fin_ready;

  sfr_cfg #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .pattern     (pattern),
    .replacement (replacement),
    .pat_len     (pat_len),
    .rep_len     (rep_len),
    .pat_wr      (pat_wr)
  );

  sfr_core #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_byte     (in_tdata),
    .in_last     (in_tlast),
    .pattern     (pattern),
    .replacement (replacement),
    .pat_len     (pat_len),
    .rep_len     (rep_len),
    .pat_wr      (pat_wr),
    .push        (push),
    .push_ready  (push_ready),
    .fin         (fin),
    .fin_ready   (fin_ready)
  );

  sfr_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .fin        (fin),
    .fin_ready  (fin_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- rtl/sfr_cfg.sv -----
// Configuration registers with length saturation and a pattern-change strobe.
module sfr_cfg #(
  parameter int MAX_PATTERN     = sfr_pkg::DEF_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = sfr_pkg::DEF_MAX_REPLACEMENT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic [sfr_pkg::TEXT_W-1:0]      pattern,
  output logic [sfr_pkg::TEXT_W-1:0]      replacement,
  output logic [sfr_pkg::LEN_W-1:0]       pat_len,
  output logic [sfr_pkg::LEN_W-1:0]       rep_len,
  output logic                            pat_wr
);
  import sfr_pkg::*;

  logic [TEXT_W-1:0] pat_r, pat_nxt;
  logic [TEXT_W-1:0] rep_r, rep_nxt;
  logic [LEN_W-1:0]  plen_r, plen_nxt;
  logic [LEN_W-1:0]  rlen_r, rlen_nxt;

  always_comb begin
    pat_nxt  = pat_r;
    rep_nxt  = rep_r;
    plen_nxt = plen_r;
    rlen_nxt = rlen_r;
    pat_wr   = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_PAT_LO: begin
          pat_nxt[CFG_DATA_W-1:0] = cfg_wdata;
          pat_wr = 1'b1;
        end
        REG_PAT_HI: begin
          pat_nxt[TEXT_W-1:CFG_DATA_W] = cfg_wdata;
          pat_wr = 1'b1;
        end
        REG_PAT_LEN: begin
          plen_nxt = cfg_wdata[LEN_W-1:0];
          pat_wr = 1'b1;
        end
        REG_REP_LO:  rep_nxt[CFG_DATA_W-1:0] = cfg_wdata;
        REG_REP_HI:  rep_nxt[TEXT_W-1:CFG_DATA_W] = cfg_wdata;
        REG_REP_LEN: rlen_nxt = cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      rep_r  <= '0;
      plen_r <= '0;
      rlen_r <= '0;
    end else begin
      pat_r  <= pat_nxt;
      rep_r  <= rep_nxt;
      plen_r <= plen_nxt;
      rlen_r <= rlen_nxt;
    end
  end

  assign pattern     = pat_r;
  assign replacement = rep_r;
  assign pat_len = (plen_r > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : plen_r;
  assign rep_len = (rlen_r > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT) : rlen_r;

endmodule

// ----- rtl/sfr_core.sv -----
// Sequencer with the shared byte comparator and the fallback table.
module sfr_core #(
  parameter int MAX_PATTERN = sfr_pkg::DEF_MAX_PATTERN
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [sfr_pkg::BYTE_W-1:0]    in_byte,
  input  logic                          in_last,
  input  logic [sfr_pkg::TEXT_W-1:0]    pattern,
  input  logic [sfr_pkg::TEXT_W-1:0]    replacement,
  input  logic [sfr_pkg::LEN_W-1:0]     pat_len,
  input  logic [sfr_pkg::LEN_W-1:0]     rep_len,
  input  logic                          pat_wr,
  output sfr_pkg::push_t                push,
  input  logic                          push_ready,
  output sfr_pkg::fin_t                 fin,
  input  logic                          fin_ready
);
  import sfr_pkg::*;

  localparam int TIW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_WALK  = 4'd1;
  localparam logic [3:0] ST_REL   = 4'd2;
  localparam logic [3:0] ST_REP   = 4'd3;
  localparam logic [3:0] ST_FLUSH = 4'd4;
  localparam logic [3:0] ST_FIN   = 4'd5;
  localparam logic [3:0] ST_BINIT = 4'd6;
  localparam logic [3:0] ST_BSTEP = 4'd7;

  logic [3:0]        state_r, state_nxt;
  logic [BYTE_W-1:0] c_r, c_nxt;
  logic              last_r, last_nxt;
  logic [LEN_W-1:0]  m_r, m_nxt;
  logic [LEN_W-1:0]  i_r, i_nxt;
  logic [LEN_W-1:0]  k_r, k_nxt;
  logic [LEN_W-1:0]  keep_r, keep_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  tbl_r [MAX_PATTERN];

  logic              building;
  logic [LEN_W-1:0]  idx_a;
  logic [BYTE_W-1:0] cmp_a, cmp_b;
  logic              eq;
  logic [LEN_W-1:0]  tbl_ra;
  logic [LEN_W-1:0]  tbl_rd;
  logic              tbl_we;
  logic [TIW-1:0]    tbl_wa;
  logic [LEN_W-1:0]  tbl_wd;
  logic              want_push;
  logic [BYTE_W-1:0] push_byte;
  logic              can_push;
  logic              step_ok;
  logic [LEN_W-1:0]  m_new;
  logic [LEN_W-1:0]  k_new;

  // Shared comparator: pattern against pattern while the table is built,
  // pattern against the current text byte while an item is scanned.
  assign building = (state_r == ST_BSTEP);
  assign idx_a    = building ? i_r : m_r;
  assign cmp_a    = pick_byte(pattern, idx_a[BIDX_W-1:0]);
  assign cmp_b    = building ? pick_byte(pattern, k_r[BIDX_W-1:0]) : c_r;
  assign eq       = (cmp_a == cmp_b);

  assign tbl_ra = building ? (k_r - LEN_W'(1)) : (m_r - LEN_W'(1));
  assign tbl_rd = tbl_r[tbl_ra[TIW-1:0]];

  assign can_push  = (cnt_r < LEN_W'(RESULT_CAP));
  assign step_ok   = !want_push || !can_push || push_ready;
  assign push.valid = want_push && can_push;
  assign push.data  = push_byte;
  assign in_tready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    c_nxt     = c_r;
    last_nxt  = last_r;
    m_nxt     = m_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    keep_nxt  = keep_r;
    cnt_nxt   = cnt_r;
    want_push = 1'b0;
    push_byte = pick_byte(pattern, i_r[BIDX_W-1:0]);
    fin.valid = 1'b0;
    fin.last  = last_r;
    tbl_we    = 1'b0;
    tbl_wa    = i_r[TIW-1:0];
    tbl_wd    = '0;
    m_new     = eq ? (m_r + LEN_W'(1)) : m_r;
    k_new     = eq ? (k_r + LEN_W'(1)) : k_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          c_nxt     = in_byte;
          last_nxt  = in_last;
          cnt_nxt   = '0;
          m_nxt     = (m_r >= pat_len) ? '0 : m_r;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        push_byte = c_r;
        if (pat_len == '0) begin
          want_push = 1'b1;
          if (step_ok) begin
            m_nxt     = '0;
            state_nxt = ST_FIN;
          end
        end else if (m_r != '0 && !eq) begin
          // Mismatch on a partial match: release the bytes the table gives up.
          keep_nxt  = (tbl_rd >= m_r) ? '0 : tbl_rd;
          i_nxt     = '0;
          state_nxt = ST_REL;
        end else begin
          want_push = !eq;
          if (step_ok) begin
            m_nxt = m_new;
            i_nxt = '0;
            if (m_new >= pat_len) begin
              state_nxt = ST_REP;
            end else if (last_r) begin
              state_nxt = ST_FLUSH;
            end else begin
              state_nxt = ST_FIN;
            end
          end
        end
      end
      ST_REL: begin
        if (i_r < (m_r - keep_r)) begin
          want_push = 1'b1;
          if (step_ok) begin
            i_nxt = i_r + LEN_W'(1);
          end
        end else begin
          m_nxt     = keep_r;
          state_nxt = ST_WALK;
        end
      end
      ST_REP: begin
        push_byte = pick_byte(replacement, i_r[BIDX_W-1:0]);
        if (i_r < rep_len) begin
          want_push = 1'b1;
          if (step_ok) begin
            i_nxt = i_r + LEN_W'(1);
          end
        end else begin
          m_nxt     = '0;
          i_nxt     = '0;
          state_nxt = last_r ? ST_FLUSH : ST_FIN;
        end
      end
      ST_FLUSH: begin
        if (i_r < m_r) begin
          want_push = 1'b1;
          if (step_ok) begin
            i_nxt = i_r + LEN_W'(1);
          end
        end else begin
          m_nxt     = '0;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        fin.valid = 1'b1;
        if (fin_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_BINIT: begin
        tbl_we    = 1'b1;
        tbl_wa    = '0;
        tbl_wd    = '0;
        i_nxt     = LEN_W'(1);
        k_nxt     = '0;
        m_nxt     = '0;
        state_nxt = (pat_len <= LEN_W'(1)) ? ST_IDLE : ST_BSTEP;
      end
      ST_BSTEP: begin
        if (k_r != '0 && !eq) begin
          k_nxt = tbl_rd;
        end else begin
          k_nxt  = k_new;
          tbl_we = 1'b1;
          tbl_wd = k_new;
          i_nxt  = i_r + LEN_W'(1);
          if ((i_r + LEN_W'(1)) >= pat_len) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (push.valid && push_ready) begin
      cnt_nxt = cnt_r + LEN_W'(1);
    end

    // A pattern change drops the partial match and rebuilds the table.
    if (pat_wr) begin
      m_nxt     = '0;
      state_nxt = ST_BINIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_BINIT;
      m_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      m_r     <= m_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r    <= c_nxt;
    last_r <= last_nxt;
    i_r    <= i_nxt;
    k_r    <= k_nxt;
    keep_r <= keep_nxt;
    if (tbl_we) begin
      tbl_r[tbl_wa] <= tbl_wd;
    end
  end

endmodule

// ----- rtl/sfr_out.sv -----
// Output stage: one byte held back to mark the end of each run, plus the output register.
module sfr_out (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sfr_pkg::push_t                push,
  output logic                          push_ready,
  input  sfr_pkg::fin_t                 fin,
  output logic                          fin_ready,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [sfr_pkg::BYTE_W-1:0]    out_tdata,
  output logic [sfr_pkg::USER_W-1:0]    out_tuser,
  output logic                          out_tlast
);
  import sfr_pkg::*;

  logic              pend_v_r, pend_v_nxt;
  logic [BYTE_W-1:0] pend_b_r, pend_b_nxt;
  logic              ov_r, ov_nxt;
  logic [BYTE_W-1:0] ob_r, ob_nxt;
  logic              obv_r, obv_nxt;
  logic              orl_r, orl_nxt;
  logic              oend_r, oend_nxt;
  logic              slot_free;

  assign slot_free  = !ov_r || out_tready;
  assign push_ready = !pend_v_r || slot_free;
  assign fin_ready  = slot_free;

  always_comb begin
    pend_v_nxt = pend_v_r;
    pend_b_nxt = pend_b_r;
    ov_nxt     = ov_r && !out_tready;
    ob_nxt     = ob_r;
    obv_nxt    = obv_r;
    orl_nxt    = orl_r;
    oend_nxt   = oend_r;
    if (push.valid && push_ready) begin
      // The held byte is known not to be the last of its run once another arrives.
      if (pend_v_r) begin
        ov_nxt   = 1'b1;
        ob_nxt   = pend_b_r;
        obv_nxt  = 1'b1;
        orl_nxt  = 1'b0;
        oend_nxt = 1'b0;
      end
      pend_v_nxt = 1'b1;
      pend_b_nxt = push.data;
    end else if (fin.valid && fin_ready) begin
      if (pend_v_r) begin
        ov_nxt     = 1'b1;
        ob_nxt     = pend_b_r;
        obv_nxt    = 1'b1;
        orl_nxt    = 1'b1;
        oend_nxt   = fin.last;
        pend_v_nxt = 1'b0;
      end else if (fin.last) begin
        // Empty end marker for a final byte that produced no text.
        ov_nxt   = 1'b1;
        ob_nxt   = '0;
        obv_nxt  = 1'b0;
        orl_nxt  = 1'b1;
        oend_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_b_r <= pend_b_nxt;
    ob_r     <= ob_nxt;
    obv_r    <= obv_nxt;
    orl_r    <= orl_nxt;
    oend_r   <= oend_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = ob_r;
  assign out_tuser  = {oend_r, obv_r};
  assign out_tlast  = orl_r;

endmodule

// ----- rtl/sfr_checker.sv -----
// Port-level checker for the stream find-and-replace block, bound to the top level.
module sfr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [sfr_pkg::BYTE_W-1:0]    out_tdata,
  input logic [sfr_pkg::USER_W-1:0]    out_tuser,
  input logic                          out_tlast
);
  import sfr_pkg::*;

  // A stalled result must stay put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("output transaction changed while stalled");

  // The end of the stream always closes the run of the byte that caused it.
  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("stream end without run end");

  // An empty marker appears only as the final result of the stream.
  a_marker_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tuser[1] && out_tlast)
    else $error("empty marker away from stream end");

  // An empty marker carries a zero byte.
  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("empty marker with nonzero data");

endmodule

bind stream_find_replace_top sfr_checker u_sfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
